// File: hdl/rv32im_subset_executor_unit_macros.svh
// Assertion macros used by the executor unit top level.
`ifndef RV32IM_SUBSET_EXECUTOR_UNIT_MACROS_SVH
`define RV32IM_SUBSET_EXECUTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising edge of clk outside reset.
`define RVX_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvx assertion failed");
// Next-cycle implication, checked on the rising edge of clk outside reset.
`define RVX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvx assertion failed");
`else
`define RVX_ASSERT_IMPL(lbl, ante, cons)
`define RVX_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hdl/rvx_pkg.sv
// Shared types, constants and the instruction classifier of the executor unit.
package rvx_pkg;

    // Data memory size in bytes and its address width.
    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    // Major opcodes.
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_LUI    = 7'h37;

    // Function codes.
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULD = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_BAD  = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_MUL  = 3'd0;
    localparam logic [2:0] F3_MULH = 3'd1;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_REM  = 3'd6;
    localparam logic [2:0] F3_B    = 3'd0;
    localparam logic [2:0] F3_H    = 3'd1;
    localparam logic [2:0] F3_W    = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

    // Ecall service numbers in a0.
    localparam logic [31:0] SVC_PRINT_INT  = 32'd1;
    localparam logic [31:0] SVC_PRINT_CHAR = 32'd11;
    localparam logic [31:0] SVC_PRINT_STR  = 32'd4;
    localparam logic [31:0] SVC_EXIT       = 32'd10;

    // Register numbers used by ecall.
    localparam logic [4:0] REG_A0 = 5'd10;
    localparam logic [4:0] REG_A1 = 5'd11;

    // Result status codes.
    localparam logic [3:0] ST_DONE      = 4'd0;
    localparam logic [3:0] ST_ILLEGAL   = 4'd1;
    localparam logic [3:0] ST_EXIT      = 4'd2;
    localparam logic [3:0] ST_PRINT_INT = 4'd3;
    localparam logic [3:0] ST_PRINT_CHR = 4'd4;
    localparam logic [3:0] ST_PRINT_STR = 4'd5;
    localparam logic [3:0] ST_BAD_ECALL = 4'd6;
    localparam logic [3:0] ST_BAD_ADDR  = 4'd7;
    localparam logic [3:0] ST_HALTED    = 4'd8;

    // Instruction classes as seen by the controller.
    typedef enum logic [3:0] {
        CLS_ALU,
        CLS_MUL,
        CLS_MULH,
        CLS_DIV,
        CLS_LOAD,
        CLS_STORE,
        CLS_BRANCH,
        CLS_JAL,
        CLS_LUI,
        CLS_ECALL,
        CLS_ILLEGAL
    } cls_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDA,
        S_RDB,
        S_CAPB,
        S_MUL,
        S_DIVI,
        S_DIV,
        S_MRD,
        S_MCAP,
        S_MWR,
        S_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_instr;
        logic rd_sel_b;
        logic cap_a;
        logic cap_b;
        logic mul_go;
        logic div_init;
        logic div_step;
        logic mem_cap;
        logic mem_wr;
        logic byte_inc;
        logic clear_wr;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cls_t cls;
        logic halted;
        logic range_ok;
        logic byte_last;
        logic div_last;
        logic clear_last;
        logic out_free;
    } stat_t;

    // Sort one instruction word into its class; anything outside the subset is illegal.
    function automatic cls_t classify(input logic [31:0] ins);
        logic [6:0] op;
        logic [2:0] f3;
        logic [6:0] f7;
        cls_t       c;
        op = ins[6:0];
        f3 = ins[14:12];
        f7 = ins[31:25];
        c  = CLS_ILLEGAL;
        case (op)
            OP_REG:
            begin
                if (f7 == F7_BASE)
                begin
                    c = (f3 == F3_BAD) ? CLS_ILLEGAL : CLS_ALU;
                end
                else if (f7 == F7_MULD)
                begin
                    case (f3)
                        F3_MUL:  c = CLS_MUL;
                        F3_MULH: c = CLS_MULH;
                        F3_DIV:  c = CLS_DIV;
                        F3_REM:  c = CLS_DIV;
                        default: c = CLS_ILLEGAL;
                    endcase
                end
                else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))
                begin
                    c = CLS_ALU;
                end
            end
            OP_IMM:
            begin
                case (f3)
                    F3_SLL:  c = (f7 == F7_BASE) ? CLS_ALU : CLS_ILLEGAL;
                    F3_SR:   c = (f7 inside {F7_BASE, F7_ALT}) ? CLS_ALU : CLS_ILLEGAL;
                    F3_BAD:  c = CLS_ILLEGAL;
                    default: c = CLS_ALU;
                endcase
            end
            OP_LOAD:   c = (f3 inside {F3_B, F3_H, F3_W}) ? CLS_LOAD : CLS_ILLEGAL;
            OP_STORE:  c = (f3 inside {F3_B, F3_H, F3_W}) ? CLS_STORE : CLS_ILLEGAL;
            OP_BRANCH: c = (f3 inside {F3_BEQ, F3_BNE}) ? CLS_BRANCH : CLS_ILLEGAL;
            OP_JAL:    c = CLS_JAL;
            OP_LUI:    c = CLS_LUI;
            OP_SYSTEM: c = (ins == ECALL_WORD) ? CLS_ECALL : CLS_ILLEGAL;
            default:   c = CLS_ILLEGAL;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/rvx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rvx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/rvx_ctrl.sv
// Controller state machine that sequences each instruction through the datapath.
module rvx_ctrl
    import rvx_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the memory clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_instr = 1'b1;
                    state_next     = st.halted ? S_FIN : S_RDA;
                end
            end
            S_RDA:
            begin
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.rd_sel_b = 1'b1;
                cmd.cap_a    = 1'b1;
                state_next   = S_CAPB;
            end
            S_CAPB:
            begin
                cmd.cap_b = 1'b1;
                case (st.cls)
                    CLS_MUL, CLS_MULH: state_next = S_MUL;
                    CLS_DIV:           state_next = S_DIVI;
                    CLS_LOAD:          state_next = st.range_ok ? S_MRD : S_FIN;
                    CLS_STORE:         state_next = st.range_ok ? S_MWR : S_FIN;
                    default:           state_next = S_FIN;
                endcase
            end
            S_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_FIN;
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_MRD:
            begin
                state_next = S_MCAP;
            end
            S_MCAP:
            begin
                cmd.mem_cap = 1'b1;
                if (st.byte_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.byte_inc = 1'b1;
                    state_next   = S_MRD;
                end
            end
            S_MWR:
            begin
                cmd.mem_wr = 1'b1;
                if (st.byte_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.byte_inc = 1'b1;
                end
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/rvx_dp.sv
// Datapath: register file, data memory, multiplier, divider and result register.
module rvx_dp
    import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] instr,
    input  cmd_t        cmd,
    output stat_t       st,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [31:0] next_pc,
    output logic        rd_written,
    output logic [4:0]  rd_index,
    output logic [31:0] rd_value,
    output logic [31:0] ecall_arg
);

    // Instruction and operand registers.
    logic [31:0] instr_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] pc_reg;
    logic        halted_reg;
    logic [31:0] vld_reg;
    logic [4:0]  ridx_reg;
    logic [63:0] prod_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [4:0]  dcnt_reg;
    logic [1:0]  bcnt_reg;
    logic [31:0] ld_reg;
    logic [MEM_AW-1:0] clr_reg;

    // Result register.
    logic        out_valid_reg;
    logic [3:0]  status_reg;
    logic [31:0] npc_reg;
    logic        wr_reg;
    logic [4:0]  rd_reg;
    logic [31:0] val_reg;
    logic [31:0] arg_reg;

    cls_t        cls;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] immi;
    logic [31:0] imms;
    logic [31:0] offb;
    logic [31:0] offj;
    logic [4:0]  rf_raddr;
    logic [31:0] rf_rdata;
    logic [31:0] rf_val;
    logic        rf_we;
    logic [31:0] base;
    logic [1:0]  nlast;
    logic [MEM_AW-1:0] baddr;
    logic        dm_we;
    logic [MEM_AW-1:0] dm_waddr;
    logic [7:0]  dm_wdata;
    logic [7:0]  dm_rdata;
    logic [32:0] dsub;
    logic [32:0] dshift;

    logic [3:0]  r_status;
    logic [31:0] r_npc;
    logic        r_wr;
    logic [31:0] r_val;
    logic [31:0] r_arg;
    logic [31:0] alu_val;
    logic [31:0] opnd;
    logic [4:0]  shamt;
    logic [31:0] div_val;
    logic [31:0] ld_val;
    logic        wr_eff;

    // Field extraction and immediates.
    assign cls  = classify(instr_reg);
    assign f3   = instr_reg[14:12];
    assign rd   = instr_reg[11:7];
    assign immi = {{20{instr_reg[31]}}, instr_reg[31:20]};
    assign imms = {{20{instr_reg[31]}}, instr_reg[31:25], instr_reg[11:7]};
    assign offb = {{19{instr_reg[31]}}, instr_reg[31], instr_reg[7], instr_reg[30:25],
                   instr_reg[11:8], 1'b0};
    assign offj = {{11{instr_reg[31]}}, instr_reg[31], instr_reg[19:12], instr_reg[20],
                   instr_reg[30:21], 1'b0};

    // Register file read address; ecall reads a0 and a1.
    always_comb
    begin
        if (cls == CLS_ECALL)
        begin
            rf_raddr = cmd.rd_sel_b ? REG_A1 : REG_A0;
        end
        else
        begin
            rf_raddr = cmd.rd_sel_b ? instr_reg[24:20] : instr_reg[19:15];
        end
    end

    rvx_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_rf (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rd),
        .wdata (r_val),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    // x0 and never-written registers read as zero.
    assign rf_val = (ridx_reg != 5'd0 && vld_reg[ridx_reg]) ? rf_rdata : 32'd0;

    // Load/store address, range check and byte count.
    assign base  = a_reg + ((cls == CLS_STORE) ? imms : immi);
    assign nlast = (f3 == F3_B) ? 2'd0 : (f3 == F3_H) ? 2'd1 : 2'd3;
    assign baddr = MEM_AW'(base + {30'd0, bcnt_reg});

    assign dm_we    = cmd.clear_wr | cmd.mem_wr;
    assign dm_waddr = cmd.clear_wr ? clr_reg : baddr;
    assign dm_wdata = cmd.clear_wr ? 8'd0 : b_reg[8*bcnt_reg +: 8];

    rvx_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_dm (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .raddr (baddr),
        .rdata (dm_rdata)
    );

    // Restoring divider step on magnitudes.
    assign dshift = {rem_reg, quo_reg[31]};
    assign dsub   = dshift - {1'b0, dvs_reg};

    // Status toward the controller.
    always_comb
    begin
        st.cls        = cls;
        st.halted     = halted_reg;
        st.range_ok   = ({1'b0, base} + 33'({nlast} + 3'd1)) <= 33'(MEM_BYTES);
        st.byte_last  = (bcnt_reg == nlast);
        st.div_last   = (dcnt_reg == 5'd31);
        st.clear_last = (clr_reg == MEM_AW'(MEM_BYTES - 1));
        st.out_free   = !out_valid_reg || !out_stall;
    end

    // Integer ALU for register and immediate forms.
    always_comb
    begin
        opnd  = (instr_reg[6:0] == OP_REG) ? b_reg : immi;
        shamt = (instr_reg[6:0] == OP_REG) ? b_reg[4:0] : instr_reg[24:20];
        case (f3)
            F3_ADD:
            begin
                if (instr_reg[6:0] == OP_REG && instr_reg[30])
                begin
                    alu_val = a_reg - b_reg;
                end
                else
                begin
                    alu_val = a_reg + opnd;
                end
            end
            F3_SLL:  alu_val = a_reg << shamt;
            F3_SLT:  alu_val = {31'd0, $signed(a_reg) < $signed(opnd)};
            F3_XOR:  alu_val = a_reg ^ opnd;
            F3_SR:   alu_val = instr_reg[30] ? 32'($signed(a_reg) >>> shamt) : a_reg >> shamt;
            F3_OR:   alu_val = a_reg | opnd;
            F3_AND:  alu_val = a_reg & opnd;
            default: alu_val = 32'd0;
        endcase
    end

    // Division result with sign fix-up and the divide-by-zero rule.
    always_comb
    begin
        if (b_reg == 32'd0)
        begin
            div_val = f3[1] ? a_reg : 32'hFFFF_FFFF;
        end
        else if (f3[1])
        begin
            div_val = a_reg[31] ? (32'd0 - rem_reg) : rem_reg;
        end
        else
        begin
            div_val = (a_reg[31] ^ b_reg[31]) ? (32'd0 - quo_reg) : quo_reg;
        end
    end

    // Load value with sign extension.
    always_comb
    begin
        case (f3)
            F3_B:    ld_val = {{24{ld_reg[7]}}, ld_reg[7:0]};
            F3_H:    ld_val = {{16{ld_reg[15]}}, ld_reg[15:0]};
            default: ld_val = ld_reg;
        endcase
    end

    // Result of the current instruction.
    always_comb
    begin
        r_status = ST_DONE;
        r_npc    = pc_reg + 32'd4;
        r_wr     = 1'b0;
        r_val    = 32'd0;
        r_arg    = 32'd0;
        if (halted_reg)
        begin
            r_status = ST_HALTED;
        end
        else
        begin
            case (cls)
                CLS_ALU:
                begin
                    r_wr  = 1'b1;
                    r_val = alu_val;
                end
                CLS_MUL:
                begin
                    r_wr  = 1'b1;
                    r_val = prod_reg[31:0];
                end
                CLS_MULH:
                begin
                    r_wr  = 1'b1;
                    r_val = prod_reg[63:32] - (a_reg[31] ? b_reg : 32'd0)
                                            - (b_reg[31] ? a_reg : 32'd0);
                end
                CLS_DIV:
                begin
                    r_wr  = 1'b1;
                    r_val = div_val;
                end
                CLS_LOAD:
                begin
                    if (st.range_ok)
                    begin
                        r_wr  = 1'b1;
                        r_val = ld_val;
                    end
                    else
                    begin
                        r_status = ST_BAD_ADDR;
                    end
                end
                CLS_STORE:
                begin
                    if (!st.range_ok)
                    begin
                        r_status = ST_BAD_ADDR;
                    end
                end
                CLS_BRANCH:
                begin
                    if ((a_reg == b_reg) == (f3 == F3_BEQ))
                    begin
                        r_npc = pc_reg + offb;
                    end
                end
                CLS_JAL:
                begin
                    r_wr  = 1'b1;
                    r_val = pc_reg + 32'd4;
                    r_npc = pc_reg + offj;
                end
                CLS_LUI:
                begin
                    r_wr  = 1'b1;
                    r_val = {instr_reg[31:12], 12'd0};
                end
                CLS_ECALL:
                begin
                    if (a_reg == SVC_PRINT_INT)
                    begin
                        r_status = ST_PRINT_INT;
                        r_arg    = b_reg;
                    end
                    else if (a_reg == SVC_PRINT_CHAR)
                    begin
                        r_status = ST_PRINT_CHR;
                        r_arg    = b_reg;
                    end
                    else if (a_reg == SVC_PRINT_STR)
                    begin
                        r_status = ST_PRINT_STR;
                        r_arg    = b_reg;
                    end
                    else if (a_reg == SVC_EXIT)
                    begin
                        r_status = ST_EXIT;
                    end
                    else
                    begin
                        r_status = ST_BAD_ECALL;
                    end
                end
                default:
                begin
                    r_status = ST_ILLEGAL;
                end
            endcase
        end
        // Halting and halted steps keep the pc.
        if (r_status inside {ST_ILLEGAL, ST_EXIT, ST_BAD_ECALL, ST_BAD_ADDR, ST_HALTED})
        begin
            r_npc = pc_reg;
            r_wr  = 1'b0;
        end
    end

    assign wr_eff = r_wr && (rd != 5'd0);
    assign rf_we  = cmd.finish && wr_eff;

    // Control registers: pc, halt flag, valid bits, counters and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= 32'd0;
            halted_reg    <= 1'b0;
            vld_reg       <= '0;
            clr_reg       <= '0;
            bcnt_reg      <= 2'd0;
            dcnt_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + MEM_AW'(1);
            end
            if (cmd.load_instr)
            begin
                bcnt_reg <= 2'd0;
            end
            else if (cmd.byte_inc)
            begin
                bcnt_reg <= bcnt_reg + 2'd1;
            end
            if (cmd.div_init)
            begin
                dcnt_reg <= 5'd0;
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + 5'd1;
            end
            if (cmd.finish)
            begin
                pc_reg <= r_npc;
                if (r_status inside {ST_ILLEGAL, ST_EXIT, ST_BAD_ECALL, ST_BAD_ADDR})
                begin
                    halted_reg <= 1'b1;
                end
                if (wr_eff)
                begin
                    vld_reg[rd] <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_instr)
        begin
            instr_reg <= instr;
        end
        ridx_reg <= rf_raddr;
        if (cmd.cap_a)
        begin
            a_reg <= rf_val;
        end
        if (cmd.cap_b)
        begin
            b_reg <= rf_val;
        end
        if (cmd.mul_go)
        begin
            prod_reg <= a_reg * b_reg;
        end
        if (cmd.div_init)
        begin
            rem_reg <= 32'd0;
            quo_reg <= a_reg[31] ? (32'd0 - a_reg) : a_reg;
            dvs_reg <= b_reg[31] ? (32'd0 - b_reg) : b_reg;
        end
        else if (cmd.div_step)
        begin
            if (!dsub[32])
            begin
                rem_reg <= dsub[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= dshift[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.mem_cap)
        begin
            ld_reg[8*bcnt_reg +: 8] <= dm_rdata;
        end
        if (cmd.load_instr)
        begin
            ld_reg <= 32'd0;
        end
        if (cmd.finish)
        begin
            status_reg <= r_status;
            npc_reg    <= r_npc;
            wr_reg     <= wr_eff;
            rd_reg     <= wr_eff ? rd : 5'd0;
            val_reg    <= wr_eff ? r_val : 32'd0;
            arg_reg    <= r_arg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign next_pc    = npc_reg;
    assign rd_written = wr_reg;
    assign rd_index   = rd_reg;
    assign rd_value   = val_reg;
    assign ecall_arg  = arg_reg;

endmodule

// File: hdl/rv32im_subset_executor_unit.sv
// Top level of the RV32IM subset executor: controller, datapath and checks.
//
// The host sends one 32-bit instruction word per request on the input channel
// (in_valid, in_stall, instr) and takes one result per request on the output
// channel (out_valid, out_stall, status, next_pc, rd_written, rd_index,
// rd_value, ecall_arg). A request is taken when valid is high and stall low.
// One instruction is executed at a time. The two register file reads go
// one after another through one RAM port. Divide and remainder use the
// one-bit-per-cycle restoring divider. Loads read and then capture data
// memory one byte at a time; stores write one byte of data memory per cycle.
// A halted block skips the operand reads and goes straight to its result.
// After reset the data memory is swept to zero, one byte per cycle, which
// keeps in_stall high until the sweep ends; registers and pc read as zero.
// The result sits in an output register; while out_stall is high it holds,
// and the next request may be accepted but its result waits behind it.
`include "rv32im_subset_executor_unit_macros.svh"
module rv32im_subset_executor_unit
    import rvx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instr,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [31:0] next_pc,
    output logic        rd_written,
    output logic [4:0]  rd_index,
    output logic [31:0] rd_value,
    output logic [31:0] ecall_arg
);

    cmd_t  cmd;
    stat_t st;
    logic  halt_result;
    logic  print_result;

    // Sequencer.
    rvx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // Execution datapath.
    rvx_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .instr      (instr),
        .cmd        (cmd),
        .st         (st),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .next_pc    (next_pc),
        .rd_written (rd_written),
        .rd_index   (rd_index),
        .rd_value   (rd_value),
        .ecall_arg  (ecall_arg)
    );

    // Status groups used by the checks below.
    assign halt_result  = status inside {ST_ILLEGAL, ST_EXIT, ST_BAD_ECALL, ST_BAD_ADDR,
                                         ST_HALTED};
    assign print_result = status inside {ST_PRINT_INT, ST_PRINT_CHR, ST_PRINT_STR};

    // A written register is never x0.
    `RVX_ASSERT_IMPL(a_no_x0_write, out_valid && rd_written, rd_index != 5'd0)
    // Halting results write nothing.
    `RVX_ASSERT_IMPL(a_halt_no_write, out_valid && halt_result, !rd_written)
    // Only one instruction is in flight.
    `RVX_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)
    // The ecall argument is only shown for print requests.
    `RVX_ASSERT_IMPL(a_arg_print, out_valid && ecall_arg != 32'd0, print_result)

endmodule

// File: dv/tb_rv32im_subset_executor_unit.sv
// Self-checking testbench for the RV32IM subset executor unit.
module tb_rv32im_subset_executor_unit;
    import rvx_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 1850;

    // One retired instruction as seen on the result port.
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] next_pc;
        logic        rd_written;
        logic [4:0]  rd_index;
        logic [31:0] rd_value;
        logic [31:0] ecall_arg;
    } retire_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] instr;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  status;
    logic [31:0] next_pc;
    logic        rd_written;
    logic [4:0]  rd_index;
    logic [31:0] rd_value;
    logic [31:0] ecall_arg;

    // Architectural state kept by the predictor.
    logic [31:0] arch_regs [0:31];
    logic [31:0] arch_pc;
    logic [7:0]  arch_mem [0:MEM_BYTES-1];
    logic        arch_halted;

    retire_t     expected_retires[$];
    int          mismatches;
    int          requests_sent;
    int          idle_pct;
    bit          hold_off_req;
    int          quiet_cycles;

    rv32im_subset_executor_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .instr      (instr),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .next_pc    (next_pc),
        .rd_written (rd_written),
        .rd_index   (rd_index),
        .rd_value   (rd_value),
        .ecall_arg  (ecall_arg)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Instruction encoders.
    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [4:0] rd,
                                          logic [4:0] rs1, logic [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // Signed divide and remainder with the RISC-V rules for zero and overflow.
    function automatic logic [31:0] div_rem(logic [31:0] a, logic [31:0] b, bit want_rem);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] r;
        if (b == 32'd0)
        begin
            return want_rem ? a : 32'hFFFF_FFFF;
        end
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
        begin
            return want_rem ? 32'd0 : 32'h8000_0000;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        r  = ma % mb;
        if (a[31] ^ b[31])
        begin
            q = -q;
        end
        if (a[31])
        begin
            r = -r;
        end
        return want_rem ? r : q;
    endfunction

    // Executes one instruction word on the predictor state and returns its result.
    function automatic retire_t compute_retire(logic [31:0] w);
        retire_t     res;
        logic [6:0]  op;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] immi;
        logic [31:0] npc;
        logic [31:0] val;
        logic [31:0] arg;
        logic [31:0] addr;
        logic [31:0] off;
        logic [63:0] prod;
        logic [3:0]  st;
        int          n;
        bit          wr;
        bit          bad;
        op   = w[6:0];
        rd   = w[11:7];
        f3   = w[14:12];
        f7   = w[31:25];
        a    = (w[19:15] == 5'd0) ? 32'd0 : arch_regs[w[19:15]];
        b    = (w[24:20] == 5'd0) ? 32'd0 : arch_regs[w[24:20]];
        immi = {{20{w[31]}}, w[31:20]};
        npc  = arch_pc + 32'd4;
        st   = ST_DONE;
        val  = 32'd0;
        arg  = 32'd0;
        wr   = 1'b0;
        bad  = 1'b0;
        n    = 0;
        if (arch_halted)
        begin
            st  = ST_HALTED;
            npc = arch_pc;
        end
        else
        begin
            case (op)
                OP_REG:
                begin
                    wr = 1'b1;
                    if (f7 == F7_BASE)
                    begin
                        case (f3)
                            F3_ADD:  val = a + b;
                            F3_SLL:  val = a << b[4:0];
                            F3_SLT:  val = {31'd0, $signed(a) < $signed(b)};
                            F3_XOR:  val = a ^ b;
                            F3_SR:   val = a >> b[4:0];
                            F3_OR:   val = a | b;
                            F3_AND:  val = a & b;
                            default: bad = 1'b1;
                        endcase
                    end
                    else if (f7 == F7_MULD)
                    begin
                        prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                        case (f3)
                            F3_MUL:  val = prod[31:0];
                            F3_MULH: val = prod[63:32];
                            F3_DIV:  val = div_rem(a, b, 1'b0);
                            F3_REM:  val = div_rem(a, b, 1'b1);
                            default: bad = 1'b1;
                        endcase
                    end
                    else if (f7 == F7_ALT && f3 == F3_ADD)
                    begin
                        val = a - b;
                    end
                    else if (f7 == F7_ALT && f3 == F3_SR)
                    begin
                        val = $signed(a) >>> b[4:0];
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                OP_IMM:
                begin
                    wr = 1'b1;
                    case (f3)
                        F3_ADD:  val = a + immi;
                        F3_SLL:
                        begin
                            if (f7 != F7_BASE)
                                bad = 1'b1;
                            else
                                val = a << w[24:20];
                        end
                        F3_SLT:  val = {31'd0, $signed(a) < $signed(immi)};
                        F3_XOR:  val = a ^ immi;
                        F3_SR:
                        begin
                            if (f7 == F7_BASE)
                                val = a >> w[24:20];
                            else if (f7 == F7_ALT)
                                val = $signed(a) >>> w[24:20];
                            else
                                bad = 1'b1;
                        end
                        F3_OR:   val = a | immi;
                        F3_AND:  val = a & immi;
                        default: bad = 1'b1;
                    endcase
                end
                OP_LOAD, OP_STORE:
                begin
                    n = (f3 == F3_B) ? 1 : (f3 == F3_H) ? 2 : (f3 == F3_W) ? 4 : 0;
                    if (op == OP_LOAD)
                        addr = a + immi;
                    else
                        addr = a + {{20{w[31]}}, f7, rd};
                    if (n == 0)
                    begin
                        bad = 1'b1;
                    end
                    else if ({32'd0, addr} + 64'(n) > 64'(MEM_BYTES))
                    begin
                        st = ST_BAD_ADDR;
                    end
                    else if (op == OP_LOAD)
                    begin
                        for (int k = 0; k < n; k++)
                        begin
                            val[8*k +: 8] = arch_mem[addr + k];
                        end
                        if (n == 1)
                            val = {{24{val[7]}}, val[7:0]};
                        else if (n == 2)
                            val = {{16{val[15]}}, val[15:0]};
                        wr = 1'b1;
                    end
                    else
                    begin
                        for (int k = 0; k < n; k++)
                        begin
                            arch_mem[addr + k] = b[8*k +: 8];
                        end
                    end
                end
                OP_BRANCH:
                begin
                    off = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                    if (f3 == F3_BEQ)
                    begin
                        if (a == b)
                            npc = arch_pc + off;
                    end
                    else if (f3 == F3_BNE)
                    begin
                        if (a != b)
                            npc = arch_pc + off;
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                OP_JAL:
                begin
                    off = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                    wr  = 1'b1;
                    val = arch_pc + 32'd4;
                    npc = arch_pc + off;
                end
                OP_LUI:
                begin
                    wr  = 1'b1;
                    val = {w[31:12], 12'd0};
                end
                OP_SYSTEM:
                begin
                    if (w != ECALL_WORD)
                        bad = 1'b1;
                    else if (arch_regs[REG_A0] == SVC_PRINT_INT)
                    begin
                        st  = ST_PRINT_INT;
                        arg = arch_regs[REG_A1];
                    end
                    else if (arch_regs[REG_A0] == SVC_PRINT_CHAR)
                    begin
                        st  = ST_PRINT_CHR;
                        arg = arch_regs[REG_A1];
                    end
                    else if (arch_regs[REG_A0] == SVC_PRINT_STR)
                    begin
                        st  = ST_PRINT_STR;
                        arg = arch_regs[REG_A1];
                    end
                    else if (arch_regs[REG_A0] == SVC_EXIT)
                        st = ST_EXIT;
                    else
                        st = ST_BAD_ECALL;
                end
                default: bad = 1'b1;
            endcase
        end
        if (bad)
        begin
            st = ST_ILLEGAL;
        end
        // Halting steps keep the pc and write nothing.
        if (st == ST_ILLEGAL || st == ST_EXIT || st == ST_BAD_ECALL || st == ST_BAD_ADDR)
        begin
            arch_halted = 1'b1;
            npc         = arch_pc;
            wr          = 1'b0;
        end
        if (st == ST_HALTED || rd == 5'd0)
        begin
            wr = 1'b0;
        end
        if (wr)
        begin
            arch_regs[rd] = val;
        end
        else
        begin
            val = 32'd0;
            rd  = 5'd0;
        end
        arch_pc        = npc;
        res.status     = st;
        res.next_pc    = npc;
        res.rd_written = wr;
        res.rd_index   = rd;
        res.rd_value   = val;
        res.ecall_arg  = arg;
        return res;
    endfunction

    // Gap length: mostly short, now and then long.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Sends one request, records its expected result, waits for acceptance and at times then idles.
    task automatic issue_instr(input logic [31:0] w);
        int gap;
        expected_retires.push_back(compute_retire(w));
        requests_sent++;
        in_valid <= 1'b1;
        instr    <= w;
        do
            @(posedge clk);
        while (in_stall);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = pick_gap();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering requests and waits until every expected result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_retires.size() != 0)
            @(posedge clk);
    endtask

    // Loads a full 32-bit constant with lui and addi.
    task automatic load_const(input logic [4:0] r, input logic [31:0] v);
        logic [31:0] hi;
        logic [31:0] lo;
        hi = (v + 32'h800) >> 12;
        lo = v - (hi << 12);
        issue_instr({hi[19:0], r, OP_LUI});
        issue_instr(enc_i(lo[11:0], r, F3_ADD, r, OP_IMM));
    endtask

    // Reaches an in-range address through a base register, then loads or stores.
    task automatic mem_access(input int n, input logic [31:0] addr, input bit is_store,
                              input logic [4:0] data_reg);
        logic [4:0]  base;
        logic [31:0] hi;
        logic [31:0] imm;
        logic [2:0]  f3;
        f3 = (n == 1) ? F3_B : (n == 2) ? F3_H : F3_W;
        if (addr < 32'd2048 && $urandom_range(0, 3) == 0)
        begin
            base = 5'd0;
            imm  = addr;
        end
        else
        begin
            // High registers only, so the directed tests keep their operands.
            base = 5'($urandom_range(24, 31));
            hi   = (addr + 32'd2048) >> 12;
            imm  = addr - (hi << 12);
            issue_instr({hi[19:0], base, OP_LUI});
        end
        if (is_store)
            issue_instr(enc_s(imm[11:0], data_reg, base, f3));
        else
            issue_instr(enc_i(imm[11:0], base, f3, data_reg, OP_LOAD));
    endtask

    // Extremes of the ALU, multiplier and divider, and writes to x0.
    task automatic test_alu_extremes();
        load_const(5'd1, 32'h8000_0000);
        issue_instr(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OP_IMM));
        issue_instr(enc_r(F7_MULD, F3_DIV, 5'd4, 5'd1, 5'd2));
        issue_instr(enc_r(F7_MULD, F3_REM, 5'd5, 5'd1, 5'd2));
        issue_instr(enc_r(F7_MULD, F3_DIV, 5'd6, 5'd1, 5'd0));
        issue_instr(enc_r(F7_MULD, F3_REM, 5'd7, 5'd1, 5'd0));
        issue_instr(enc_r(F7_MULD, F3_MULH, 5'd8, 5'd1, 5'd1));
        issue_instr(enc_r(F7_MULD, F3_MUL, 5'd9, 5'd2, 5'd2));
        issue_instr(enc_r(F7_ALT, F3_SR, 5'd12, 5'd1, 5'd2));
        issue_instr(enc_r(F7_BASE, F3_SLL, 5'd13, 5'd2, 5'd2));
        issue_instr(enc_r(F7_BASE, F3_SLT, 5'd14, 5'd1, 5'd2));
        issue_instr(enc_i({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd15, OP_IMM));
        issue_instr(enc_i({F7_BASE, 5'd31}, 5'd2, F3_SR, 5'd16, OP_IMM));
        issue_instr(enc_r(F7_ALT, F3_ADD, 5'd17, 5'd0, 5'd1));
        issue_instr(enc_i(12'h800, 5'd2, F3_SLT, 5'd18, OP_IMM));
        // A write to x0 is dropped and x0 still reads as zero.
        issue_instr(enc_r(F7_BASE, F3_ADD, 5'd0, 5'd2, 5'd2));
        issue_instr(enc_r(F7_BASE, F3_OR, 5'd19, 5'd0, 5'd0));
        wait_drained();
    endtask

    // Memory at the top boundary, a misaligned half and a wrapping address.
    task automatic test_memory_edges();
        mem_access(4, MEM_BYTES - 4, 1'b1, 5'd1);
        mem_access(1, MEM_BYTES - 1, 1'b0, 5'd20);
        mem_access(2, MEM_BYTES - 3, 1'b0, 5'd21);
        mem_access(4, MEM_BYTES - 4, 1'b0, 5'd22);
        // Base of all ones plus one wraps to address zero.
        issue_instr(enc_i(12'h001, 5'd2, F3_B, 5'd23, OP_LOAD));
        wait_drained();
    endtask

    // Branches both ways with extreme offsets, jal forward and back, and ecalls.
    task automatic test_control_and_ecalls();
        issue_instr(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ));
        issue_instr(enc_b(13'h0FFE, 5'd2, 5'd1, F3_BNE));
        issue_instr(enc_b(13'h0FFE, 5'd2, 5'd1, F3_BEQ));
        issue_instr(enc_j(21'h0FFFFE, 5'd1));
        issue_instr(enc_j(21'h100000, 5'd0));
        issue_instr(enc_i(SVC_PRINT_INT[11:0], 5'd0, F3_ADD, REG_A0, OP_IMM));
        issue_instr(ECALL_WORD);
        issue_instr(enc_i(SVC_PRINT_CHAR[11:0], 5'd0, F3_ADD, REG_A0, OP_IMM));
        issue_instr(ECALL_WORD);
        issue_instr(enc_i(SVC_PRINT_STR[11:0], 5'd0, F3_ADD, REG_A0, OP_IMM));
        issue_instr(ECALL_WORD);
        wait_drained();
    endtask

    // One random legal instruction or short well-formed sequence.
    task automatic random_step();
        logic [2:0]  f3;
        logic [31:0] v;
        logic [31:0] addr;
        logic [31:0] specials [5];
        int          n;
        specials = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        case ($urandom_range(0, 9))
            0, 1:
            begin
                do
                    f3 = 3'($urandom_range(0, 7));
                while (f3 == F3_BAD);
                issue_instr(enc_r(F7_BASE, f3, 5'($urandom), 5'($urandom), 5'($urandom)));
            end
            2:
            begin
                if ($urandom_range(0, 1))
                    issue_instr(enc_r(F7_ALT, $urandom_range(0, 1) ? F3_ADD : F3_SR,
                                      5'($urandom), 5'($urandom), 5'($urandom)));
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       f3 = F3_MUL;
                        1:       f3 = F3_MULH;
                        2:       f3 = F3_DIV;
                        default: f3 = F3_REM;
                    endcase
                    issue_instr(enc_r(F7_MULD, f3, 5'($urandom), 5'($urandom),
                                      5'($urandom)));
                end
            end
            3, 4:
            begin
                do
                    f3 = 3'($urandom_range(0, 7));
                while (f3 == F3_BAD);
                v = $urandom;
                if (f3 == F3_SLL)
                    v[11:5] = F7_BASE;
                else if (f3 == F3_SR)
                    v[11:5] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
                issue_instr(enc_i(v[11:0], 5'($urandom), f3, 5'($urandom), OP_IMM));
            end
            5:
            begin
                if ($urandom_range(0, 1))
                    load_const(5'($urandom), specials[$urandom_range(0, 4)]);
                else
                    load_const(5'($urandom), $urandom);
            end
            6, 7:
            begin
                // Store, then read back with a random width.
                n = 1 << $urandom_range(0, 2);
                if ($urandom_range(0, 9) == 0)
                    addr = $urandom_range(MEM_BYTES - 8, MEM_BYTES - 4);
                else if ($urandom_range(0, 1))
                    addr = $urandom_range(0, 255);
                else
                    addr = $urandom_range(0, MEM_BYTES - 4);
                mem_access(n, addr, 1'b1, 5'($urandom));
                mem_access(1 << $urandom_range(0, 2), addr, 1'b0, 5'($urandom));
            end
            8:
            begin
                v = $urandom;
                case ($urandom_range(0, 2))
                    0:       issue_instr(enc_b(13'($urandom), 5'($urandom), 5'($urandom),
                                               $urandom_range(0, 1) ? F3_BEQ : F3_BNE));
                    1:       issue_instr(enc_j(21'($urandom), 5'($urandom)));
                    default: issue_instr({v[31:12], v[11:7], OP_LUI});
                endcase
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       v = SVC_PRINT_INT;
                    1:       v = SVC_PRINT_CHAR;
                    default: v = SVC_PRINT_STR;
                endcase
                issue_instr(enc_i(v[11:0], 5'd0, F3_ADD, REG_A0, OP_IMM));
                if ($urandom_range(0, 1))
                    load_const(REG_A1, $urandom);
                issue_instr(ECALL_WORD);
            end
        endcase
    endtask

    // Long random run with the idle rate changing between stretches.
    task automatic test_random_mix();
        int stretch;
        stretch = 0;
        while (requests_sent < RANDOM_ITEMS)
        begin
            if (stretch == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 20;
                    default: idle_pct = 50;
                endcase
                stretch = 150;
            end
            random_step();
            stretch--;
        end
        wait_drained();
    endtask

    // The receiver holds off while the sender keeps offering requests.
    task automatic test_backpressure();
        idle_pct     = 0;
        hold_off_req = 1'b1;
        repeat (12) random_step();
        wait_drained();
        idle_pct = 20;
    endtask

    // Halts the block one of four ways, then checks that everything after is ignored.
    task automatic test_halt();
        logic [31:0] w;
        logic [6:0]  op;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        do
                            op = 7'($urandom_range(0, 127));
                        while (op inside {OP_REG, OP_IMM, OP_SYSTEM, OP_BRANCH, OP_JAL,
                                          OP_STORE, OP_LOAD, OP_LUI});
                        w = {$urandom} & 32'hFFFF_FF80 | {25'd0, op};
                    end
                    1:       w = enc_r(F7_BASE, F3_BAD, 5'($urandom), 5'($urandom),
                                       5'($urandom));
                    2:       w = enc_i({7'h40, 5'd3}, 5'($urandom), F3_SLL, 5'($urandom),
                                       OP_IMM);
                    default:
                    begin
                        w = {$urandom} & 32'hFFFF_FF80 | {25'd0, OP_SYSTEM};
                        if (w == ECALL_WORD)
                            w[20] = 1'b1;
                    end
                endcase
                issue_instr(w);
            end
            1:
            begin
                issue_instr(enc_i(SVC_EXIT[11:0], 5'd0, F3_ADD, REG_A0, OP_IMM));
                issue_instr(ECALL_WORD);
            end
            2:
            begin
                issue_instr(enc_i(12'd7, 5'd0, F3_ADD, REG_A0, OP_IMM));
                issue_instr(ECALL_WORD);
            end
            default:
            begin
                // A word that straddles the top of memory is out of range.
                mem_access(4, MEM_BYTES - 2, 1'b0, 5'd3);
            end
        endcase
        repeat (30) issue_instr($urandom);
        wait_drained();
    endtask

    // Receiver: random stalls, plus one long hold on request.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                out_stall <= 1'b1;
                repeat (pick_gap()) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        retire_t got;
        retire_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, next_pc, rd_written, rd_index, rd_value, ecall_arg};
            if (expected_retires.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with no request pending: %p", got);
            end
            else
            begin
                want = expected_retires.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                                 want, got);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_rv32im_subset_executor_unit NOT OK");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        instr         = 32'd0;
        mismatches    = 0;
        requests_sent = 0;
        idle_pct      = 20;
        hold_off_req  = 1'b0;
        quiet_cycles  = 0;
        arch_pc       = 32'd0;
        arch_halted   = 1'b0;
        for (int i = 0; i < 32; i++)
            arch_regs[i] = 32'd0;
        for (int i = 0; i < MEM_BYTES; i++)
            arch_mem[i] = 8'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alu_extremes();
        test_memory_edges();
        test_control_and_ecalls();
        test_random_mix();
        test_backpressure();
        test_halt();

        in_valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_retires.size() != 0)
        begin
            mismatches++;
            $display("ERROR: %0d results never arrived", expected_retires.size());
        end
        if (mismatches == 0)
            $display("tb_rv32im_subset_executor_unit OK");
        else
            $display("tb_rv32im_subset_executor_unit NOT OK");
        $finish;
    end

endmodule
